### rtl/core/spn64_pkg.sv
// Shared constants, substitution tables and bit transpose for the 64-bit SPN cipher.
package spn64_pkg;

  localparam int unsigned BLOCK_W   = 64;
  localparam int unsigned KEY_BYTES = 19;
  localparam int unsigned KEY_W     = 8 * KEY_BYTES;
  localparam int unsigned NUM_ROUNDS = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Mode bit codes
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_0_7   = 2'd0,
    REG_KEY_8_15  = 2'd1,
    REG_KEY_16_18 = 2'd2
  } cfg_reg_e;

  // Encryption substitution (inverse AES S-box)
  localparam logic [7:0] SUB_ENC [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Decryption substitution (forward AES S-box)
  localparam logic [7:0] SUB_DEC [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Transpose the block as an 8x8 bit matrix, byte 0 being row 0
  function automatic logic [BLOCK_W-1:0] transpose8x8(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    y = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        y[63 - (8 * r + c)] = x[63 - (8 * c + r)];
      end
    end
    return y;
  endfunction

endpackage

### rtl/core/spn64_round.sv
// One cipher round: key mix, byte substitution, key mix and, but for the final round, bit transpose, either direction.
module spn64_round (
  input  logic                              mode_i,
  input  logic                              first_i,
  input  logic                              last_i,
  input  logic [spn64_pkg::BLOCK_W-1:0]     data_i,
  input  logic [spn64_pkg::BLOCK_W-1:0]     enc_key_i,
  input  logic [spn64_pkg::BLOCK_W-1:0]     dec_key_i,
  input  logic [spn64_pkg::BLOCK_W-1:0]     post_key_i,
  output logic [spn64_pkg::BLOCK_W-1:0]     data_o
);

  logic [spn64_pkg::BLOCK_W-1:0] pre_key;
  logic [spn64_pkg::BLOCK_W-1:0] mixed;
  logic [spn64_pkg::BLOCK_W-1:0] subbed;
  logic [spn64_pkg::BLOCK_W-1:0] late_key;
  logic [spn64_pkg::BLOCK_W-1:0] post;

  // Select the key mixed in before and after the substitution
  always_comb begin
    if (mode_i == spn64_pkg::MODE_ENC) begin
      pre_key  = enc_key_i;
      late_key = last_i ? post_key_i : '0;
    end else begin
      pre_key  = first_i ? post_key_i : '0;
      late_key = dec_key_i;
    end
  end

  assign mixed = data_i ^ pre_key;

  // Substitute every byte through the table of the active direction
  always_comb begin
    subbed = '0;
    for (int b = 0; b < 8; b++) begin
      if (mode_i == spn64_pkg::MODE_ENC) begin
        subbed[8*b +: 8] = spn64_pkg::SUB_ENC[mixed[8*b +: 8]];
      end else begin
        subbed[8*b +: 8] = spn64_pkg::SUB_DEC[mixed[8*b +: 8]];
      end
    end
  end

  assign post = subbed ^ late_key;

  // The final round leaves out the transpose
  assign data_o = last_i ? post : spn64_pkg::transpose8x8(post);

endmodule

### rtl/core/spn64_block_cipher.sv
// Top level of the 64-bit SPN block cipher: key registers and the round pipeline.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) transfers a mode bit and a 64-bit block;
//   mode 0 encrypts, mode 1 decrypts. Output channel (out_valid_o / out_ready_i)
//   transfers the 64-bit result. Results leave in the order the blocks entered.
//   The 19-byte key is loaded through the write port (cfg_we_i, cfg_index_i,
//   cfg_wdata_i): index 0 holds key bytes 0..7, index 1 bytes 8..15, index 2
//   bytes 16..18 in its low 24 bits; other indexes are ignored. Load the key only
//   while no block is in flight.
//   One register stage per round, the last one being the output register.
//   Throughput: one block per cycle unless the output stalls; each of the 11 rounds
//   has its own substitution tables and transpose wiring, so blocks overlap freely.
//   Reset clears the key to zero and empties the pipeline.
//   When the receiver stalls, the stages fill up behind the held result and
//   in_ready_o drops only once every stage holds a block; empty stages close up.
module spn64_block_cipher (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spn64_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spn64_pkg::BLOCK_W-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [spn64_pkg::BLOCK_W-1:0]       block_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [spn64_pkg::BLOCK_W-1:0]       block_out_o
);

  localparam int unsigned NR = spn64_pkg::NUM_ROUNDS;

  logic [spn64_pkg::KEY_W-1:0]   key_q;
  logic [NR-1:0]                 valid_q;
  logic [NR-2:0]                 mode_q;
  logic [spn64_pkg::BLOCK_W-1:0] data_q [NR];
  logic [spn64_pkg::BLOCK_W-1:0] round_out [NR];
  logic [NR:0]                   adv;

  // Load key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spn64_pkg::REG_KEY_0_7:   key_q[151:88] <= cfg_wdata_i;
        spn64_pkg::REG_KEY_8_15:  key_q[87:24]  <= cfg_wdata_i;
        spn64_pkg::REG_KEY_16_18: key_q[23:0]   <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the one after it advances
  always_comb begin
    adv[NR] = out_ready_i;
    for (int j = NR - 1; j >= 0; j--) begin
      adv[j] = !valid_q[j] || adv[j+1];
    end
  end

  assign in_ready_o = adv[0];

  // Round logic per stage
  for (genvar j = 0; j < NR; j++) begin : g_round
    logic [spn64_pkg::BLOCK_W-1:0] stage_in;
    logic                          stage_mode;

    if (j == 0) begin : g_first
      assign stage_in   = block_in_i;
      assign stage_mode = mode_i;
    end else begin : g_rest
      assign stage_in   = data_q[j-1];
      assign stage_mode = mode_q[j-1];
    end

    spn64_round u_round (
      .mode_i     (stage_mode),
      .first_i    (1'(j == 0)),
      .last_i     (1'(j == NR - 1)),
      .data_i     (stage_in),
      .enc_key_i  (key_q[spn64_pkg::KEY_W-1-8*j -: spn64_pkg::BLOCK_W]),
      .dec_key_i  (key_q[spn64_pkg::KEY_W-1-8*(NR-1-j) -: spn64_pkg::BLOCK_W]),
      .post_key_i (key_q[spn64_pkg::BLOCK_W-1:0]),
      .data_o     (round_out[j])
    );
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int j = 1; j < NR; j++) begin
        if (adv[j]) begin
          valid_q[j] <= valid_q[j-1];
        end
      end
    end
  end

  // Advance payload; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      data_q[0] <= round_out[0];
      mode_q[0] <= mode_i;
    end
    for (int j = 1; j < NR; j++) begin
      if (adv[j]) begin
        data_q[j] <= round_out[j];
      end
    end
    for (int j = 1; j < NR - 1; j++) begin
      if (adv[j]) begin
        mode_q[j] <= mode_q[j-1];
      end
    end
  end

  assign out_valid_o = valid_q[NR-1];
  assign block_out_o = data_q[NR-1];

endmodule

### tb/tb_spn64_block_cipher.sv
// Self-checking testbench for the 64-bit SPN block cipher: random traffic, key loads, stalls.
module tb_spn64_block_cipher;
  import spn64_pkg::*;

  localparam int unsigned LATENCY = NUM_ROUNDS;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned HOLD_CYCLES = 80;
  // No register sits at this index; writes to it must leave the key alone
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam logic [BLOCK_W-1:0] ALL_ONES = {BLOCK_W{1'b1}};

  typedef struct packed {
    logic               mode;
    logic [BLOCK_W-1:0] blk;
  } blk_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [BLOCK_W-1:0]   cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i = MODE_ENC;
  logic [BLOCK_W-1:0]   block_in_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [BLOCK_W-1:0]   block_out_o;

  // Shadow of the key as the block holds it, byte 0 in the top bits
  logic [KEY_W-1:0]     key_shadow = '0;

  blk_item_t            pending_blocks[$];
  logic [BLOCK_W-1:0]   expected_blocks[$];
  int                   in_flight = 0;
  int                   errors = 0;
  int                   n_enc = 0;
  int                   n_dec = 0;
  int                   n_checked = 0;
  int                   n_key_loads = 0;
  bit                   quiet = 1'b0;
  bit                   hold_req = 1'b0;
  bit                   hold_done = 1'b0;
  int unsigned          hold_left = 0;
  int unsigned          src_gap = 0;
  int unsigned          sink_gap = 0;
  logic                 in_took = 1'b0;

  spn64_block_cipher u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .block_in_i  (block_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .block_out_o (block_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Round key r is key bytes r..r+7
  function automatic logic [BLOCK_W-1:0] round_key(input int unsigned r);
    return key_shadow[KEY_W-1-8*r -: BLOCK_W];
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_bytes(input logic [BLOCK_W-1:0] x,
                                                   input logic dec);
    logic [BLOCK_W-1:0] y;
    y = '0;
    for (int b = 0; b < 8; b++) begin
      if (dec) y[8*b +: 8] = SUB_DEC[x[8*b +: 8]];
      else     y[8*b +: 8] = SUB_ENC[x[8*b +: 8]];
    end
    return y;
  endfunction

  // Swap rows and columns of the 8x8 bit matrix; row 0 is the top byte
  function automatic logic [BLOCK_W-1:0] flip_matrix(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] y;
    for (int row = 0; row < 8; row++) begin
      for (int col = 0; col < 8; col++) begin
        y[63 - 8*row - col] = x[63 - 8*col - row];
      end
    end
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] cipher_block(input logic mode,
                                                      input logic [BLOCK_W-1:0] blk);
    logic [BLOCK_W-1:0] x;
    logic [BLOCK_W-1:0] v;
    logic [BLOCK_W-1:0] w;
    x = blk;
    v = '0;
    w = '0;
    if (mode == MODE_ENC) begin
      // The final transpose is dropped: the last substitution meets the last key
      for (int i = 0; i < NUM_ROUNDS; i++) begin
        v = sub_bytes(x ^ round_key(i), 1'b0);
        x = flip_matrix(v);
      end
      return v ^ round_key(NUM_ROUNDS);
    end
    v = x ^ round_key(NUM_ROUNDS);
    for (int i = NUM_ROUNDS; i > 0; i--) begin
      w = sub_bytes(v, 1'b1) ^ round_key(i - 1);
      v = flip_matrix(w);
    end
    return w;
  endfunction

  // Mostly short gaps, now and then a long one; none in quiet phases or under hold
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || hold_left != 0) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [BLOCK_W-1:0] pick_block();
    int unsigned r;
    logic [BLOCK_W-1:0] b;
    r = $urandom_range(9);
    b = '0;
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    if (r == 2) begin
      b[$urandom_range(BLOCK_W - 1)] = 1'b1;
      return b;
    end
    return {$urandom, $urandom};
  endfunction

  task automatic queue_block(input logic mode, input logic [BLOCK_W-1:0] blk);
    blk_item_t it;
    it.mode = mode;
    it.blk = blk;
    pending_blocks.push_back(it);
    in_flight++;
  endtask

  task automatic queue_both(input logic [BLOCK_W-1:0] blk);
    queue_block(MODE_ENC, blk);
    queue_block(MODE_DEC, blk);
  endtask

  // One register write, then mirror it in the shadow key
  task automatic load_key(input logic [CFG_IDX_W-1:0] idx, input logic [BLOCK_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_KEY_0_7:   key_shadow[151:88] = val;
      REG_KEY_8_15:  key_shadow[87:24] = val;
      REG_KEY_16_18: key_shadow[23:0] = val[23:0];
      default: ;
    endcase
    n_key_loads++;
  endtask

  // Wait until every queued block has come back, then let the pipeline drain
  task automatic wait_idle();
    while (in_flight != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  // Sender: hold an offered block until its transfer, then gap or offer the next
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // hold
    end else if (src_gap != 0) begin
      in_valid_i <= 1'b0;
      src_gap <= src_gap - 1;
    end else if (pending_blocks.size() != 0) begin
      blk_item_t it;
      it = pending_blocks.pop_front();
      in_valid_i <= 1'b1;
      mode_i <= it.mode;
      block_in_i <= it.blk;
      src_gap <= next_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: random stalls, and once a long hold-off that backs up the pipeline
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (sink_gap != 0) begin
      out_ready_i <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      sink_gap <= next_gap();
    end
  end

  // Predict on each input transfer, check on each output transfer
  always @(posedge clk_i) begin
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_blocks.push_back(cipher_block(mode_i, block_in_i));
      if (mode_i == MODE_ENC) n_enc++;
      else n_dec++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_blocks.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected result block_out=%h", block_out_o);
      end else begin
        logic [BLOCK_W-1:0] want;
        want = expected_blocks.pop_front();
        in_flight--;
        n_checked++;
        if (block_out_o !== want) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("block_out mismatch: expected %h, got %h", want, block_out_o);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Key as it comes out of reset
    queue_both('0);
    queue_both(ALL_ONES);
    wait_idle();

    // All-ones key; wide data into the short register, noise at the unused index
    load_key(REG_KEY_0_7, ALL_ONES);
    load_key(REG_KEY_8_15, ALL_ONES);
    load_key(REG_KEY_16_18, ALL_ONES);
    load_key(REG_NONE, {$urandom, $urandom});
    queue_both('0);
    queue_both(ALL_ONES);
    queue_both(64'h0123_4567_89ab_cdef);
    queue_both(64'h8000_0000_0000_0000);
    queue_both(64'h0000_0000_0000_0001);
    queue_both(64'ha5a5_a5a5_a5a5_a5a5);
    queue_both(64'h5a5a_5a5a_5a5a_5a5a);
    wait_idle();

    // Key bytes that all differ, so any misplaced round key shows
    load_key(REG_KEY_0_7, 64'h0001_0203_0405_0607);
    load_key(REG_KEY_8_15, 64'h0809_0a0b_0c0d_0e0f);
    load_key(REG_KEY_16_18, 64'hdead_beef_0010_1112);
    queue_both(64'hfedc_ba98_7654_3210);
    wait_idle();

    // Random phases, each under its own key
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          load_key(REG_KEY_0_7, '0);
          load_key(REG_KEY_8_15, '0);
          load_key(REG_KEY_16_18, '0);
        end
        1: begin
          load_key(REG_KEY_0_7, ALL_ONES);
          load_key(REG_KEY_8_15, ALL_ONES);
          load_key(REG_KEY_16_18, 64'h0000_0000_00ff_ffff);
        end
        default: begin
          load_key(REG_KEY_0_7, {$urandom, $urandom});
          load_key(REG_KEY_8_15, {$urandom, $urandom});
          load_key(REG_KEY_16_18, {$urandom, $urandom});
          if ($urandom_range(1) == 1) load_key(REG_NONE, {$urandom, $urandom});
        end
      endcase
      quiet = (p == 2);
      @(negedge clk_i);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_block($urandom_range(1) ? MODE_DEC : MODE_ENC, pick_block());
      end
      if (p == 4) hold_req = 1'b1;
      wait_idle();
    end

    repeat (LATENCY + 4) @(posedge clk_i);
    if (expected_blocks.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", expected_blocks.size());
    end
    $display("Checked %0d blocks (%0d encrypt, %0d decrypt) across %0d key writes,",
             n_checked, n_enc, n_dec, n_key_loads);
    $display("with random gaps on both sides and one long output stall.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #(12 * 900_000);
    $display("timeout with %0d blocks outstanding", in_flight);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
